FILE: rtl/sbda_pkg.sv
package sbda_pkg;

	// Bits of the magnitude that every digit cell takes in per conversion cycle.
	localparam int BPS = 4;

	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_FIND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

FILE: rtl/sbda_cell.sv
module sbda_cell import sbda_pkg::*; (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [BPS-1:0]   bits_in,
	output logic [BPS-1:0]   bits_out,
	output logic [3:0]       digit
);

	logic [3:0] digit_q;
	logic [3:0] digit_d;

	// Each bit step adjusts the digit by three when it is five or more, then
	// shifts one bit in from the lower cell and one bit out to the upper cell.
	always_comb begin
		logic [3:0] d;
		d = digit_q;
		bits_out = '0;
		for (int j = 0; j < BPS; j++) begin
			if (d >= 4'd5) begin
				d = d + 4'd3;
			end
			bits_out[BPS-1-j] = d[3];
			d = {d[2:0], bits_in[BPS-1-j]};
		end
		digit_d = d;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.shift) begin
			digit_q <= digit_d;
		end
	end

	assign digit = digit_q;

endmodule

FILE: rtl/signed_binary_to_decimal_ascii_unit.sv
// Signed binary to decimal ASCII converter.
// The value channel (value_valid, value_stall, value) takes one signed
// two's complement integer of VALUE_BITS bits per transfer. The character
// channel (character_valid, character_stall, character, last) returns its
// decimal text one ASCII character per transfer: a minus sign first for a
// negative value, then the digits most significant first, with leading zeros
// dropped; zero gives a single '0'. last marks the final character of a run.
// The magnitude enters a row of BCD digit cells four bits per cycle, then a
// separate state locates the leading digit. Characters then leave at one
// per cycle when not stalled. A new value is taken once the last character
// of the previous run sits in the output register.
// A stall on the character channel holds the output register and the run
// resumes when it is released. Reset empties the output register and returns
// the block to idle, ready for a value.
module signed_binary_to_decimal_ascii_unit import sbda_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  value_valid,
	output logic                  value_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  character_valid,
	input  logic                  character_stall,
	output logic [7:0]            character,
	output logic                  last
);

	localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
	localparam int STEPS      = (VALUE_BITS + BPS - 1) / BPS;
	localparam int PAD_BITS   = STEPS * BPS;
	localparam int CNT_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	state_t               state_q;
	state_t               state_d;
	logic [PAD_BITS-1:0]  mag_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 sign_q;
	logic                 valid_q;
	logic [7:0]           char_q;
	logic                 last_q;

	logic [VALUE_BITS-1:0] mag_abs;
	logic [IDX_W-1:0]      top_idx;
	logic                  out_free;
	logic                  load;
	logic                  emit;
	cell_ctrl_t            ctrl;
	logic [BPS-1:0]        chain [NUM_DIGITS];
	logic [3:0]            digit [NUM_DIGITS];

	assign mag_abs  = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
	assign out_free = !valid_q || !character_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		emit       = 1'b0;
		ctrl.clear = 1'b0;
		ctrl.shift = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (value_valid) begin
					load       = 1'b1;
					ctrl.clear = 1'b1;
					state_d    = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				ctrl.shift = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (!sign_q && idx_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign value_stall = (state_q != ST_IDLE);

	// The lowest cell takes the magnitude bits; each cell feeds the next one up.
	assign chain[0] = mag_q[PAD_BITS-1 -: BPS];

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i < NUM_DIGITS - 1) begin : g_mid
			sbda_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.bits_in  (chain[i]),
				.bits_out (chain[i+1]),
				.digit    (digit[i])
			);
		end else begin : g_top
			sbda_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.bits_in  (chain[i]),
				.bits_out (),
				.digit    (digit[i])
			);
		end
	end

	// Highest nonzero digit; zero leaves the index at the units digit.
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (digit[i] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= PAD_BITS'(mag_abs);
		end else if (ctrl.shift) begin
			mag_q <= mag_q << BPS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
			sign_q <= 1'b0;
		end else begin
			if (load) begin
				neg_q <= value[VALUE_BITS-1];
				cnt_q <= CNT_W'(STEPS - 1);
			end else if (ctrl.shift) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (state_q == ST_FIND) begin
				idx_q  <= top_idx;
				sign_q <= neg_q;
			end else if (emit) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (!character_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= sign_q ? CH_MINUS : (CH_ZERO + {4'd0, digit[idx_q]});
			last_q <= !sign_q && (idx_q == '0);
		end
	end

	assign character_valid = valid_q;
	assign character       = char_q;
	assign last            = last_q;

endmodule

FILE: rtl/sbda_checker.sv
module sbda_checker import sbda_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  value_valid,
	input logic                  value_stall,
	input logic [VALUE_BITS-1:0] value,
	input logic                  character_valid,
	input logic                  character_stall,
	input logic [7:0]            character,
	input logic                  last
);

	// A held character stays put until it is transferred.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid && character_stall |=>
			character_valid && $stable(character) && $stable(last))
		else $error("stalled character changed");

	// Only a minus sign or a decimal digit ever leaves the block.
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid |->
			(character == CH_MINUS) ||
			(character >= CH_ZERO && character <= CH_ZERO + 8'd9))
		else $error("character outside the decimal set");

	// A minus sign is always followed by at least one digit.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		character_valid && character == CH_MINUS |-> !last)
		else $error("minus sign marked as last");

	// After taking a value the block is busy converting it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_stall |=> value_stall)
		else $error("second value taken during a conversion");

	// A value that waits on a stall is held by the sender.
	a_value_hold: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_stall |=> value_valid && $stable(value))
		else $error("stalled value changed");

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker #(.VALUE_BITS(VALUE_BITS)) u_sbda_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.value_valid     (value_valid),
	.value_stall     (value_stall),
	.value           (value),
	.character_valid (character_valid),
	.character_stall (character_stall),
	.character       (character),
	.last            (last)
);
